// File: sv/sprd_pkg.sv
// Package for the spherical panoramic ray direction unit.
// Holds the fixed-point widths, angle constants, register indexes, cell payload
// types and the CORDIC arctangent table. No dependencies.
`default_nettype none
package sprd_pkg;

  localparam int NUM_W   = 31;
  localparam int DEN_W   = 13;
  localparam int QM_W    = 20;
  localparam int ANG_W   = 23;
  localparam int CW      = 33;
  localparam int TRIG_W  = 19;
  localparam int BASIS_W = 16;
  localparam int PROD_W  = 35;
  localparam int SUM_W   = 37;
  localparam int OUT_W   = 17;
  localparam int IDX_W   = 5;
  localparam int IX_W    = 3;
  localparam int CFG_W   = 48;
  localparam int DIV_STAGES = 31;
  localparam int MOD_STAGES = 12;

  localparam logic [NUM_W-1:0] TWO_PI_U = 31'd823550;
  localparam logic signed [ANG_W-1:0] PI_A      = 23'sd411775;
  localparam logic signed [ANG_W-1:0] HALF_PI_A = 23'sd205887;
  localparam logic signed [ANG_W-1:0] TWO_PI_A  = 23'sd823550;
  localparam logic signed [CW-1:0]    CORDIC_GAIN = 33'sd652032874;

  localparam logic signed [OUT_W-1:0] OUT_MAX = 17'sd65535;
  localparam logic signed [OUT_W-1:0] OUT_MIN = -17'sd65536;

  localparam logic [IX_W-1:0] REG_HRES  = 3'd0;
  localparam logic [IX_W-1:0] REG_VRES  = 3'd1;
  localparam logic [IX_W-1:0] REG_AZ    = 3'd2;
  localparam logic [IX_W-1:0] REG_POLAR = 3'd3;
  localparam logic [IX_W-1:0] REG_BU    = 3'd4;
  localparam logic [IX_W-1:0] REG_BV    = 3'd5;
  localparam logic [IX_W-1:0] REG_BW    = 3'd6;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic             neg;
  } div_t;

  typedef struct packed {
    logic [NUM_W-1:0] v;
    logic             neg;
  } mod_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 neg;
  } cordic_t;

  function automatic logic signed [CW-1:0] atan_q30(input logic [IDX_W-1:0] i);
    logic signed [CW-1:0] r;
    case (i)
      5'd0:  r = 33'sd843314856;
      5'd1:  r = 33'sd497837829;
      5'd2:  r = 33'sd263043836;
      5'd3:  r = 33'sd133525158;
      5'd4:  r = 33'sd67021686;
      5'd5:  r = 33'sd33543515;
      5'd6:  r = 33'sd16775850;
      5'd7:  r = 33'sd8388437;
      5'd8:  r = 33'sd4194282;
      5'd9:  r = 33'sd2097149;
      5'd10: r = 33'sd1048575;
      5'd11: r = 33'sd524287;
      5'd12: r = 33'sd262143;
      5'd13: r = 33'sd131071;
      5'd14: r = 33'sd65535;
      5'd15: r = 33'sd32767;
      5'd16: r = 33'sd16383;
      5'd17: r = 33'sd8191;
      5'd18: r = 33'sd4095;
      5'd19: r = 33'sd2047;
      5'd20: r = 33'sd1023;
      5'd21: r = 33'sd511;
      5'd22: r = 33'sd255;
      5'd23: r = 33'sd127;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/sprd_div_cell.sv
// One restoring division cell: resolves one quotient bit per cycle while en is high.
// Depends on sprd_pkg.
`default_nettype none
module sprd_div_cell (
  input  wire logic         clk,
  input  wire logic         en,
  input  sprd_pkg::div_t    d,
  output sprd_pkg::div_t    q
);
  import sprd_pkg::*;

  logic [DEN_W:0] trial;
  logic [DEN_W:0] diff;
  logic           ge;

  assign trial = {d.rem, d.num[NUM_W-1]};
  assign diff  = trial - {1'b0, d.den};
  assign ge    = trial >= {1'b0, d.den};

  always_ff @(posedge clk) begin
    if (en) begin
      q.rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      q.num <= {d.num[NUM_W-2:0], ge};
      q.den <= d.den;
      q.neg <= d.neg;
    end
  end
endmodule
`default_nettype wire

// File: sv/sprd_mod_cell.sv
// One modulo reduction cell: subtracts a scaled copy of 2pi when it fits.
// Depends on sprd_pkg.
`default_nettype none
module sprd_mod_cell (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [sprd_pkg::NUM_W-1:0] step,
  input  sprd_pkg::mod_t                  d,
  output sprd_pkg::mod_t                  q
);
  import sprd_pkg::*;

  logic ge;

  assign ge = d.v >= step;

  always_ff @(posedge clk) begin
    if (en) begin
      q.v   <= ge ? d.v - step : d.v;
      q.neg <= d.neg;
    end
  end
endmodule
`default_nettype wire

// File: sv/sprd_cordic_cell.sv
// One rotation-mode CORDIC cell: one micro-rotation per cycle while en is high.
// Depends on sprd_pkg (arctangent table).
`default_nettype none
module sprd_cordic_cell (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [sprd_pkg::IDX_W-1:0] idx,
  input  sprd_pkg::cordic_t               d,
  output sprd_pkg::cordic_t               q
);
  import sprd_pkg::*;

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [CW-1:0] at;

  assign xs = d.x >>> idx;
  assign ys = d.y >>> idx;
  assign at = atan_q30(idx);

  always_ff @(posedge clk) begin
    if (en) begin
      if (!d.z[CW-1]) begin
        q.x <= d.x - ys;
        q.y <= d.y + xs;
        q.z <= d.z - at;
      end else begin
        q.x <= d.x + ys;
        q.y <= d.y - xs;
        q.z <= d.z + at;
      end
      q.neg <= d.neg;
    end
  end
endmodule
`default_nettype wire

// File: sv/spherical_panoramic_ray_direction_unit.sv
// Throughput: one request per cycle; the pipeline stalls as a whole only while a
// result waits at the output. Depth is set by the 31-cell restoring divider,
// the 12-cell modulo chain and the CORDIC cell row.
// Reset (rst, synchronous): clears all valid flags and loads register defaults.
// Depends on sprd_pkg, sprd_div_cell, sprd_mod_cell, sprd_cordic_cell.
`default_nettype none
module spherical_panoramic_ray_direction_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [15:0]           pixel_x,
  input  wire logic signed [15:0]           pixel_y,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [sprd_pkg::OUT_W-1:0] dir_x,
  output logic signed [sprd_pkg::OUT_W-1:0] dir_y,
  output logic signed [sprd_pkg::OUT_W-1:0] dir_z,
  input  wire logic                         cfg_we,
  input  wire logic [sprd_pkg::IX_W-1:0]    cfg_index,
  input  wire logic [sprd_pkg::CFG_W-1:0]   cfg_data
);
  import sprd_pkg::*;

  localparam int LAT = 50 + CORDIC_STEPS;

  logic [12:0] hres, vres;
  logic [14:0] az_lim;
  logic [13:0] pol_lim;
  logic [CFG_W-1:0] basis_u, basis_v, basis_w;

  logic [LAT-1:0] vld;
  logic en;

  assign en        = out_ready | ~vld[LAT-1];
  assign in_ready  = en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      hres    <= 13'd640;
      vres    <= 13'd480;
      az_lim  <= 15'd25736;
      pol_lim <= 14'd12868;
      basis_u <= 48'd16384;
      basis_v <= 48'd16384 << 16;
      basis_w <= 48'd16384 << 32;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HRES:  hres    <= cfg_data[12:0];
        REG_VRES:  vres    <= cfg_data[12:0];
        REG_AZ:    az_lim  <= cfg_data[14:0];
        REG_POLAR: pol_lim <= cfg_data[13:0];
        REG_BU:    basis_u <= cfg_data;
        REG_BV:    basis_v <= cfg_data;
        REG_BW:    basis_w <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // scale: 2 * |offset| * limit + den/2
  logic [15:0] mag_x, mag_y;
  logic [DEN_W-1:0] den_x, den_y;
  logic [31:0] px, py;

  assign mag_x = pixel_x[15] ? 16'(-pixel_x) : 16'(pixel_x);
  assign mag_y = pixel_y[15] ? 16'(-pixel_y) : 16'(pixel_y);
  assign den_x = (hres == '0) ? DEN_W'(1) : hres;
  assign den_y = (vres == '0) ? DEN_W'(1) : vres;
  assign px    = {mag_x, 1'b0} * az_lim;
  assign py    = {mag_y, 1'b0} * pol_lim;

  div_t div_x [DIV_STAGES+1];
  div_t div_y [DIV_STAGES+1];

  always_ff @(posedge clk) begin
    if (en) begin
      div_x[0].rem <= '0;
      div_x[0].num <= NUM_W'(px) + NUM_W'(den_x >> 1);
      div_x[0].den <= den_x;
      div_x[0].neg <= pixel_x[15];
      div_y[0].rem <= '0;
      div_y[0].num <= NUM_W'(py) + NUM_W'(den_y >> 1);
      div_y[0].den <= den_y;
      div_y[0].neg <= pixel_y[15];
    end
  end

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    sprd_div_cell u_dx (.clk(clk), .en(en), .d(div_x[i]), .q(div_x[i+1]));
    sprd_div_cell u_dy (.clk(clk), .en(en), .d(div_y[i]), .q(div_y[i+1]));
  end

  mod_t mod_x [MOD_STAGES+1];
  mod_t mod_y [MOD_STAGES+1];

  assign mod_x[0].v   = div_x[DIV_STAGES].num;
  assign mod_x[0].neg = div_x[DIV_STAGES].neg;
  assign mod_y[0].v   = div_y[DIV_STAGES].num;
  assign mod_y[0].neg = div_y[DIV_STAGES].neg;

  for (genvar k = 0; k < MOD_STAGES; k++) begin : g_mod
    localparam logic [NUM_W-1:0] STEP = TWO_PI_U << (MOD_STAGES - 1 - k);
    sprd_mod_cell u_mx (.clk(clk), .en(en), .step(STEP), .d(mod_x[k]), .q(mod_x[k+1]));
    sprd_mod_cell u_my (.clk(clk), .en(en), .step(STEP), .d(mod_y[k]), .q(mod_y[k+1]));
  end

  function automatic logic signed [ANG_W-1:0] wrap_angle(
    input logic [QM_W-1:0] qm, input logic neg, input logic signed [ANG_W-1:0] base);
    logic signed [ANG_W-1:0] lam;
    logic signed [ANG_W-1:0] t;
    lam = neg ? -$signed(ANG_W'(qm)) : $signed(ANG_W'(qm));
    t   = base - lam;
    if (t < 0) begin
      t = t + TWO_PI_A;
    end else if (t >= TWO_PI_A) begin
      t = t - TWO_PI_A;
    end
    return t;
  endfunction

  function automatic cordic_t fold_angle(input logic signed [ANG_W-1:0] t);
    logic signed [ANG_W-1:0] r;
    cordic_t c;
    r = (t > PI_A) ? t - TWO_PI_A : t;
    c.neg = 1'b0;
    if (r > HALF_PI_A) begin
      r = r - PI_A;
      c.neg = 1'b1;
    end else if (r < -HALF_PI_A) begin
      r = r + PI_A;
      c.neg = 1'b1;
    end
    c.x = CORDIC_GAIN;
    c.y = '0;
    c.z = CW'(r) <<< 13;
    return c;
  endfunction

  logic signed [ANG_W-1:0] f1_x, f1_y;
  cordic_t cx [CORDIC_STEPS+1];
  cordic_t cy [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      f1_x  <= wrap_angle(mod_x[MOD_STAGES].v[QM_W-1:0], mod_x[MOD_STAGES].neg, PI_A);
      f1_y  <= wrap_angle(mod_y[MOD_STAGES].v[QM_W-1:0], mod_y[MOD_STAGES].neg, HALF_PI_A);
      cx[0] <= fold_angle(f1_x);
      cy[0] <= fold_angle(f1_y);
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    sprd_cordic_cell u_cx (.clk(clk), .en(en), .idx(IDX_W'(i)), .d(cx[i]), .q(cx[i+1]));
    sprd_cordic_cell u_cy (.clk(clk), .en(en), .idx(IDX_W'(i)), .d(cy[i]), .q(cy[i+1]));
  end

  function automatic logic signed [TRIG_W-1:0] round_q16(
    input logic signed [CW-1:0] v, input logic neg);
    logic signed [CW-1:0] f;
    logic signed [CW-1:0] s;
    f = neg ? -v : v;
    s = f + CW'(8192);
    return $signed(s[CW-1:14]);
  endfunction

  logic signed [TRIG_W-1:0] sp, cp, st, ct, ct_p, a_p, c_p;
  logic signed [2*TRIG_W-1:0] pa, pc;
  logic signed [2*TRIG_W-1:0] pa_r, pc_r;

  assign pa   = st * sp;
  assign pc   = st * cp;
  assign pa_r = pa + (2*TRIG_W)'(32768);
  assign pc_r = pc + (2*TRIG_W)'(32768);

  always_ff @(posedge clk) begin
    if (en) begin
      sp   <= round_q16(cx[CORDIC_STEPS].y, cx[CORDIC_STEPS].neg);
      cp   <= round_q16(cx[CORDIC_STEPS].x, cx[CORDIC_STEPS].neg);
      st   <= round_q16(cy[CORDIC_STEPS].y, cy[CORDIC_STEPS].neg);
      ct   <= round_q16(cy[CORDIC_STEPS].x, cy[CORDIC_STEPS].neg);
      a_p  <= $signed(pa_r[16+TRIG_W-1:16]);
      c_p  <= $signed(pc_r[16+TRIG_W-1:16]);
      ct_p <= ct;
    end
  end

  logic signed [OUT_W-1:0] dir [3];

  for (genvar k = 0; k < 3; k++) begin : g_comp
    logic signed [BASIS_W-1:0] bu, bv, bw;
    logic signed [PROD_W-1:0] mu, mv, mw;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-16-1:0] rr;

    assign bu  = $signed(basis_u[BASIS_W*k +: BASIS_W]);
    assign bv  = $signed(basis_v[BASIS_W*k +: BASIS_W]);
    assign bw  = $signed(basis_w[BASIS_W*k +: BASIS_W]);
    assign sum = SUM_W'(mu) + SUM_W'(mv) + SUM_W'(mw) + SUM_W'(32768);
    assign rr  = $signed(sum[SUM_W-1:16]);

    always_ff @(posedge clk) begin
      if (en) begin
        mu <= a_p * bu;
        mv <= ct_p * bv;
        mw <= c_p * bw;
        if (rr > (SUM_W-16)'(OUT_MAX)) begin
          dir[k] <= OUT_MAX;
        end else if (rr < (SUM_W-16)'(OUT_MIN)) begin
          dir[k] <= OUT_MIN;
        end else begin
          dir[k] <= rr[OUT_W-1:0];
        end
      end
    end
  end

  assign dir_x = dir[0];
  assign dir_y = dir[1];
  assign dir_z = dir[2];

endmodule
`default_nettype wire

// File: sv/sprd_checker.sv
// Port-level checks for the ray direction unit, bound to the top level.
// Depends on sprd_pkg and spherical_panoramic_ray_direction_unit.
`default_nettype none
module sprd_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic signed [sprd_pkg::OUT_W-1:0] dir_x,
  input wire logic signed [sprd_pkg::OUT_W-1:0] dir_y,
  input wire logic signed [sprd_pkg::OUT_W-1:0] dir_z
);
  import sprd_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  a_ready_tracks_output: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("intake not tied to output drain");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(dir_x) && $stable(dir_y)
      && $stable(dir_z))
    else $error("stalled result changed");

  a_no_accept_in_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !(in_valid && in_ready))
    else $error("request taken while pipeline frozen");

endmodule

bind spherical_panoramic_ray_direction_unit sprd_checker u_sprd_checker (.*);
`default_nettype wire
